>>> rtl/headlamp_light_controller_assert.svh
// assertion macros shared by the lamp controller rtl
`ifndef HEADLAMP_LIGHT_CONTROLLER_ASSERT_SVH
`define HEADLAMP_LIGHT_CONTROLLER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define HLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition that must be followed by another in the following cycle
`define HLC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/hlc_pkg.sv
// shared types and constants of the lamp controller
package hlc_pkg;

    localparam int CMD_W      = 2;
    localparam int LEVEL_W    = 10;
    localparam int SW_W       = 8;
    localparam int LAMP_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_SAMPLE  = 2'd0;
    localparam cmd_t CMD_BLINK   = 2'd1;
    localparam cmd_t CMD_DOOR    = 2'd2;
    localparam cmd_t CMD_REFRESH = 2'd3;

    localparam cfg_idx_t CFG_THRESHOLD = 1'd0;
    localparam cfg_idx_t CFG_MANUAL    = 1'd1;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd500;

    // switch bit positions
    localparam int SW_DAY   = 0;
    localparam int SW_LOW   = 1;
    localparam int SW_HIGH  = 2;
    localparam int SW_LEFT  = 3;
    localparam int SW_RIGHT = 4;
    localparam int SW_CABIN = 6;

    // lamp bit positions
    localparam int LAMP_DAY   = 7;
    localparam int LAMP_LOW   = 6;
    localparam int LAMP_HIGH  = 5;
    localparam int LAMP_LEFT  = 4;
    localparam int LAMP_RIGHT = 3;
    localparam int LAMP_CABIN = 0;

endpackage

>>> rtl/headlamp_light_controller.sv
// Headlamp controller: windowed light average and automatic lamp sequencing.
//
// Input channel (s_valid/s_ready) carries one command per transaction: a
// light sample, a blink tick, a door update or a refresh. Every input
// transaction yields exactly one result transaction on the m_ channel with
// the lamp bits, the current average and the automatic lamp states.
// Configuration (threshold, manual mode) is written via cfg_wr_en, cfg_index
// and cfg_wdata with no handshake; users write only while idle (unenforced).
//
// A light sample steps through the SUM, DIV, DECIDE and FINISH states: one
// shared adder/subtractor first accumulates the filled window entries one per
// cycle, then runs a restoring divide by the fill count, one quotient bit per
// cycle. Other commands go from acceptance straight to FINISH. In FINISH the
// result is loaded into the output register and s_ready returns. s_ready is
// high only while the sequencer is idle, so one transaction is in work at a
// time.
// The result sits in an output register; a new transaction is accepted while
// it waits, and a finished one holds in the sequencer until the receiver
// takes the previous result. Synchronous active-low reset empties the window,
// clears all lamp state and restores threshold 500 and automatic mode.
module headlamp_light_controller #(
    parameter int WINDOW_LEN      = 10,
    parameter int OFF_DELAY_TICKS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hlc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [hlc_pkg::LEVEL_W-1:0]    s_light_level,
    input  logic                           s_door_open,
    input  logic [hlc_pkg::SW_W-1:0]       s_switches,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hlc_pkg::LAMP_W-1:0]     m_lamps,
    output logic [hlc_pkg::LEVEL_W-1:0]    m_light_average,
    output logic                           m_day_lamp_on,
    output logic                           m_low_beam_on,
    input  logic                           cfg_wr_en,
    input  logic [hlc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hlc_pkg::*;

    `include "headlamp_light_controller_assert.svh"

    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = $clog2(WINDOW_LEN * ((1 << LEVEL_W) - 1) + 1);
    localparam int ALU_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int DLY_W  = $clog2(OFF_DELAY_TICKS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUM    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [LEVEL_W-1:0] window_reg [WINDOW_LEN];

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]   filled_count_reg, filled_count_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LEVEL_W-1:0] average_reg, average_next;
    logic               day_lamp_reg, day_lamp_next;
    logic               low_beam_reg, low_beam_next;
    logic [DLY_W-1:0]   delay_count_reg, delay_count_next;
    logic               delay_running_reg, delay_running_next;
    logic               blink_phase_reg, blink_phase_next;
    logic               door_latched_reg, door_latched_next;
    logic [SW_W-1:0]    switches_reg, switches_next;
    logic [LEVEL_W-1:0] threshold_reg;
    logic               manual_reg;

    logic               m_valid_reg, m_valid_next;
    logic [LAMP_W-1:0]  m_lamps_reg, m_lamps_next;
    logic [LEVEL_W-1:0] m_average_reg, m_average_next;
    logic               m_day_reg, m_day_next;
    logic               m_low_reg, m_low_next;

    logic               accept;
    logic               window_we;

    // shared adder/subtractor
    logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
    logic               alu_sub;
    logic [CNT_W:0]     trial;
    logic [LAMP_W-1:0]  lamps;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign window_we = accept && (s_cmd == CMD_SAMPLE);

    assign trial = {rem_reg, acc_reg[SUM_W-1]};
    assign alu_y = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);

    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_a   = ALU_W'(trial);
            alu_b   = ALU_W'(filled_count_reg);
            alu_sub = 1'b1;
        end else begin
            alu_a   = {1'b0, acc_reg};
            alu_b   = ALU_W'(window_reg[k_reg[IDX_W-1:0]]);
            alu_sub = 1'b0;
        end
    end

    always_comb begin
        lamps = '0;
        if (manual_reg) begin
            lamps[LAMP_DAY]   = switches_reg[SW_DAY];
            lamps[LAMP_LOW]   = switches_reg[SW_LOW];
            lamps[LAMP_CABIN] = switches_reg[SW_CABIN];
        end else begin
            lamps[LAMP_DAY]   = day_lamp_reg;
            lamps[LAMP_LOW]   = low_beam_reg;
            lamps[LAMP_CABIN] = door_latched_reg;
        end
        lamps[LAMP_HIGH]  = switches_reg[SW_HIGH];
        lamps[LAMP_LEFT]  = blink_phase_reg && switches_reg[SW_LEFT];
        lamps[LAMP_RIGHT] = blink_phase_reg && switches_reg[SW_RIGHT];
    end

    always_comb begin
        state_next         = state_reg;
        write_slot_next    = write_slot_reg;
        filled_count_next  = filled_count_reg;
        k_next             = k_reg;
        acc_next           = acc_reg;
        rem_next           = rem_reg;
        step_next          = step_reg;
        average_next       = average_reg;
        day_lamp_next      = day_lamp_reg;
        low_beam_next      = low_beam_reg;
        delay_count_next   = delay_count_reg;
        delay_running_next = delay_running_reg;
        blink_phase_next   = blink_phase_reg;
        door_latched_next  = door_latched_reg;
        switches_next      = switches_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_lamps_next       = m_lamps_reg;
        m_average_next     = m_average_reg;
        m_day_next         = m_day_reg;
        m_low_next         = m_low_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    switches_next = s_switches;
                    state_next    = ST_FINISH;
                    case (s_cmd)
                        CMD_SAMPLE: begin
                            if (write_slot_reg == IDX_W'(WINDOW_LEN - 1)) begin
                                write_slot_next = '0;
                            end else begin
                                write_slot_next = write_slot_reg + 1'b1;
                            end
                            if (filled_count_reg < CNT_W'(WINDOW_LEN)) begin
                                filled_count_next = filled_count_reg + 1'b1;
                            end
                            k_next     = '0;
                            acc_next   = '0;
                            state_next = ST_SUM;
                        end
                        CMD_BLINK: begin
                            blink_phase_next = !blink_phase_reg;
                            if (delay_running_reg) begin
                                if (DLY_W'(delay_count_reg + 1'b1) >=
                                    DLY_W'(OFF_DELAY_TICKS)) begin
                                    delay_count_next   = '0;
                                    delay_running_next = 1'b0;
                                    low_beam_next      = 1'b0;
                                end else begin
                                    delay_count_next = delay_count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_DOOR: begin
                            door_latched_next = s_door_open;
                        end
                        CMD_REFRESH: begin
                            door_latched_next = door_latched_reg;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                if (k_reg == filled_count_reg) begin
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    acc_next = alu_y[SUM_W-1:0];
                    k_next   = k_reg + 1'b1;
                end
            end
            ST_DIV: begin
                // restoring divide, borrow out of the shared unit picks the bit
                if (alu_y[ALU_W-1]) begin
                    rem_next = trial[CNT_W-1:0];
                    acc_next = {acc_reg[SUM_W-2:0], 1'b0};
                end else begin
                    rem_next = alu_y[CNT_W-1:0];
                    acc_next = {acc_reg[SUM_W-2:0], 1'b1};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                average_next = acc_reg[LEVEL_W-1:0];
                state_next   = ST_FINISH;
                if (!manual_reg) begin
                    if (acc_reg[LEVEL_W-1:0] > threshold_reg) begin
                        day_lamp_next = 1'b1;
                        if (low_beam_reg && !delay_running_reg) begin
                            delay_count_next   = '0;
                            delay_running_next = 1'b1;
                        end
                    end else begin
                        day_lamp_next      = 1'b0;
                        low_beam_next      = 1'b1;
                        delay_count_next   = '0;
                        delay_running_next = 1'b0;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_lamps_next   = lamps;
                    m_average_next = average_reg;
                    m_day_next     = day_lamp_reg;
                    m_low_next     = low_beam_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            write_slot_reg    <= '0;
            filled_count_reg  <= '0;
            average_reg       <= '0;
            day_lamp_reg      <= 1'b0;
            low_beam_reg      <= 1'b0;
            delay_count_reg   <= '0;
            delay_running_reg <= 1'b0;
            blink_phase_reg   <= 1'b0;
            door_latched_reg  <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            write_slot_reg    <= write_slot_next;
            filled_count_reg  <= filled_count_next;
            average_reg       <= average_next;
            day_lamp_reg      <= day_lamp_next;
            low_beam_reg      <= low_beam_next;
            delay_count_reg   <= delay_count_next;
            delay_running_reg <= delay_running_next;
            blink_phase_reg   <= blink_phase_next;
            door_latched_reg  <= door_latched_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        switches_reg  <= switches_next;
        m_lamps_reg   <= m_lamps_next;
        m_average_reg <= m_average_next;
        m_day_reg     <= m_day_next;
        m_low_reg     <= m_low_next;
    end

    // entries past the fill count are never summed, so no clearing is needed
    always_ff @(posedge aclk) begin
        if (window_we) begin
            window_reg[write_slot_reg] <= s_light_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            manual_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_MANUAL:    manual_reg    <= cfg_wdata[0];
                default:       manual_reg    <= manual_reg;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lamps         = m_lamps_reg;
    assign m_light_average = m_average_reg;
    assign m_day_lamp_on   = m_day_reg;
    assign m_low_beam_on   = m_low_reg;

    `HLC_ASSERT(a_fill_bound, filled_count_reg <= CNT_W'(WINDOW_LEN), "fill count past window")
    `HLC_ASSERT(a_sum_index, (state_reg != ST_SUM) || (k_reg <= filled_count_reg), "sum index past fill")
    `HLC_ASSERT(a_delay_bound, !delay_running_reg || (delay_count_reg < DLY_W'(OFF_DELAY_TICKS)), "delay count overrun")
    `HLC_ASSERT(a_delay_idle, delay_running_reg || (delay_count_reg == '0), "idle delay not cleared")
    `HLC_ASSERT_NEXT(a_finish_out, (state_reg == ST_FINISH) && !m_valid_reg, m_valid_reg && (state_reg == ST_IDLE), "finished result not loaded")

endmodule

>>> bench/headlamp_light_controller_test.sv
// self-checking testbench for the headlamp controller: random traffic with a lamp predictor
`timescale 1ns / 100ps

module headlamp_light_controller_test;
    import hlc_pkg::*;

    localparam int WINDOW_LEN      = 10;
    localparam int OFF_DELAY_TICKS = 10;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 400;

    typedef struct {
        cmd_t               cmd;
        logic [LEVEL_W-1:0] level;
        logic               door;
        logic [SW_W-1:0]    sw;
    } lamp_cmd_t;

    typedef struct {
        logic [LAMP_W-1:0]  lamps;
        logic [LEVEL_W-1:0] average;
        logic               day;
        logic               low;
    } lamp_status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    cmd_t                  s_cmd = CMD_REFRESH;
    logic [LEVEL_W-1:0]    s_light_level = '0;
    logic                  s_door_open = 1'b0;
    logic [SW_W-1:0]       s_switches = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LAMP_W-1:0]     m_lamps;
    logic [LEVEL_W-1:0]    m_light_average;
    logic                  m_day_lamp_on;
    logic                  m_low_beam_on;
    logic                  cfg_wr_en = 1'b0;
    cfg_idx_t              cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    headlamp_light_controller #(
        .WINDOW_LEN      (WINDOW_LEN),
        .OFF_DELAY_TICKS (OFF_DELAY_TICKS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_light_level   (s_light_level),
        .s_door_open     (s_door_open),
        .s_switches      (s_switches),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lamps         (m_lamps),
        .m_light_average (m_light_average),
        .m_day_lamp_on   (m_day_lamp_on),
        .m_low_beam_on   (m_low_beam_on),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // lamp predictor state
    logic [LEVEL_W-1:0] window_q [WINDOW_LEN];
    int unsigned        slot_q;
    int unsigned        filled_q;
    logic [LEVEL_W-1:0] average_q;
    logic               day_q;
    logic               low_q;
    int unsigned        delay_ticks_q;
    logic               delay_on_q;
    logic               blink_q;
    logic               door_q;
    logic [LEVEL_W-1:0] threshold_q;
    logic               manual_q;

    lamp_cmd_t    pending_cmds [$];
    lamp_status_t expected_status [$];
    int           mismatches = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           holds_armed = 0;
    int           holds_taken = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    function automatic lamp_status_t apply_command(lamp_cmd_t c);
        lamp_status_t r;
        int unsigned  total;
        int unsigned  k;
        total = 0;
        case (c.cmd)
            CMD_SAMPLE: begin
                window_q[slot_q] = c.level;
                slot_q = (slot_q + 1) % WINDOW_LEN;
                if (filled_q < WINDOW_LEN) filled_q++;
                for (k = 0; k < filled_q; k++) total += window_q[k];
                average_q = LEVEL_W'(total / filled_q);
                if (!manual_q) begin
                    if (average_q > threshold_q) begin
                        day_q = 1'b1;
                        if (low_q && !delay_on_q) begin
                            delay_ticks_q = 0;
                            delay_on_q = 1'b1;
                        end
                    end else begin
                        day_q = 1'b0;
                        low_q = 1'b1;
                        delay_ticks_q = 0;
                        delay_on_q = 1'b0;
                    end
                end
            end
            CMD_BLINK: begin
                blink_q = ~blink_q;
                if (delay_on_q) begin
                    delay_ticks_q++;
                    if (delay_ticks_q >= OFF_DELAY_TICKS) begin
                        delay_ticks_q = 0;
                        delay_on_q = 1'b0;
                        low_q = 1'b0;
                    end
                end
            end
            CMD_DOOR: door_q = c.door;
            default: ;
        endcase
        r.lamps = '0;
        if (manual_q) begin
            r.lamps[LAMP_DAY]   = c.sw[SW_DAY];
            r.lamps[LAMP_LOW]   = c.sw[SW_LOW];
            r.lamps[LAMP_CABIN] = c.sw[SW_CABIN];
        end else begin
            r.lamps[LAMP_DAY]   = day_q;
            r.lamps[LAMP_LOW]   = low_q;
            r.lamps[LAMP_CABIN] = door_q;
        end
        r.lamps[LAMP_HIGH]  = c.sw[SW_HIGH];
        r.lamps[LAMP_LEFT]  = blink_q & c.sw[SW_LEFT];
        r.lamps[LAMP_RIGHT] = blink_q & c.sw[SW_RIGHT];
        r.average = average_q;
        r.day     = day_q;
        r.low     = low_q;
        return r;
    endfunction

    function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // driver: offers pending commands, predicts each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_status.push_back(apply_command('{s_cmd, s_light_level,
                                                          s_door_open, s_switches}));
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid       <= 1'b1;
                    s_cmd         <= pending_cmds[0].cmd;
                    s_light_level <= pending_cmds[0].level;
                    s_door_open   <= pending_cmds[0].door;
                    s_switches    <= pending_cmds[0].sw;
                    void'(pending_cmds.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, long hold-off on request, result check
    always @(posedge aclk) begin
        lamp_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing expected", $realtime);
                end else begin
                    want = expected_status.pop_front();
                    if (m_lamps !== want.lamps)
                        report_mismatch("lamps", want.lamps, m_lamps);
                    if (m_light_average !== want.average)
                        report_mismatch("light_average", want.average, m_light_average);
                    if (m_day_lamp_on !== want.day)
                        report_mismatch("day_lamp_on", want.day, m_day_lamp_on);
                    if (m_low_beam_on !== want.low)
                        report_mismatch("low_beam_on", want.low, m_low_beam_on);
                end
            end
            if (hold_left == 0 && holds_taken != holds_armed) begin
                holds_taken = holds_armed;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_cmd(cmd_t cmd, int level, bit door, int sw);
        pending_cmds.push_back('{cmd, LEVEL_W'(level), door, SW_W'(sw)});
    endtask

    task automatic push_random_cmd();
        push_cmd(cmd_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(1),
                 $urandom_range(255));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_THRESHOLD)
            threshold_q = data;
        else
            manual_q = data[0];
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // bright runs followed by mostly blink ticks (not always enough to finish the
    // off delay), dark runs, and plain noise
    task automatic queue_traffic(int count);
        int pushed;
        int pick;
        int n;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_cmd(CMD_SAMPLE, (threshold_q >= 1023) ? 1023
                             : $urandom_range(1023, int'(threshold_q) + 1),
                             $urandom_range(1), $urandom_range(255));
                pushed += n;
                n = $urandom_range(14, 6);
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        push_random_cmd();
                    else
                        push_cmd(CMD_BLINK, $urandom_range(1023), $urandom_range(1),
                                 $urandom_range(255));
                end
                pushed += n;
            end else if (pick < 70) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_cmd(CMD_SAMPLE, $urandom_range(int'(threshold_q), 0),
                             $urandom_range(1), $urandom_range(255));
                pushed += n;
                n = $urandom_range(3, 0);
                repeat (n)
                    push_cmd(CMD_BLINK, $urandom_range(1023), $urandom_range(1),
                             $urandom_range(255));
                pushed += n;
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) push_random_cmd();
                pushed += n;
            end
        end
    endtask

    task automatic run_phase(int thr, bit manual, int send_idle, int recv_stall, int count,
                             bit long_hold);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_MANUAL, {9'($urandom_range(511)), manual});
        sender_idle_pct = send_idle;
        receiver_stall_pct = recv_stall;
        if (long_hold) holds_armed++;
        queue_traffic(count);
        wait_drained();
    endtask

    initial begin
        foreach (window_q[k]) window_q[k] = '0;
        slot_q = 0;
        filled_q = 0;
        average_q = '0;
        day_q = 1'b0;
        low_q = 1'b0;
        delay_ticks_q = 0;
        delay_on_q = 1'b0;
        blink_q = 1'b0;
        door_q = 1'b0;
        threshold_q = THRESHOLD_RESET;
        manual_q = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, no sample yet, then a full day/night cycle
        push_cmd(CMD_REFRESH, 0, 0, 8'h00);
        push_cmd(CMD_REFRESH, 1023, 1, 8'hFF);
        push_cmd(CMD_BLINK, 0, 0, 8'hFF);
        push_cmd(CMD_DOOR, 0, 1, 8'h00);
        push_cmd(CMD_SAMPLE, 0, 0, 8'hA0);
        push_cmd(CMD_SAMPLE, 1023, 0, 8'h5F);
        repeat (OFF_DELAY_TICKS) push_cmd(CMD_BLINK, 0, 0, 8'h18);
        push_cmd(CMD_SAMPLE, 1000, 0, 8'hFF);
        push_cmd(CMD_DOOR, 0, 0, 8'h40);
        push_cmd(CMD_SAMPLE, 0, 0, 8'h00);
        push_cmd(CMD_SAMPLE, 0, 0, 8'h04);
        push_cmd(CMD_REFRESH, 0, 0, 8'hFF);
        push_cmd(CMD_SAMPLE, 1023, 1, 8'h18);
        wait_drained();

        run_phase(500, 1'b0, 0, 0, 150, 1'b1);
        run_phase(0, 1'b0, 79, 0, 155, 1'b0);
        run_phase(1023, 1'b0, 0, 79, 155, 1'b0);
        run_phase(1000, 1'b1, 21, 21, 155, 1'b0);
        run_phase($urandom_range(1023), 1'b0, 21, 21, 155, 1'b0);
        run_phase($urandom_range(1023), 1'b1, 0, 79, 155, 1'b0);

        // catch any stray result after the last one
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hlc_pkg.sv
rtl/headlamp_light_controller.sv
bench/headlamp_light_controller_test.sv
